### hdl/tcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants for the text console cursor writer.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Nametable geometry; cell count is a power of two between 4096 and 16384
  localparam int unsigned NT_CELLS     = 16384;
  localparam int unsigned NT_IDX_W     = 14;
  localparam logic [NT_IDX_W-1:0] NT_IDX_MASK = NT_IDX_W'(NT_CELLS - 1);

  localparam int unsigned COL_W  = 6;
  localparam int unsigned ROW_W  = 8;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned VAL_W  = 16;

  // Item kinds carried on the input tuser
  localparam logic FUNC_PUT = 1'b0;
  localparam logic FUNC_SET = 1'b1;

  // Character codes and cursor limits
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'd10;
  localparam logic [CHAR_W-1:0] CH_LAST_CTRL = 8'd31;
  localparam logic [COL_W-1:0]  COL_ADV_MAX  = 6'd61;
  localparam logic [ROW_W-1:0]  ROW_BUMP_MAX = 8'd46;
  localparam logic [VAL_W-1:0]  CELL_MARK    = 16'h8000;

  // One input item
  typedef struct packed {
    logic              func;
    logic [CHAR_W-1:0] char_byte;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
  } tcc_item_t;

  // One result item
  typedef struct packed {
    logic                cell_written;
    logic [NT_IDX_W-1:0] cell_index;
    logic [VAL_W-1:0]    cell_value;
  } tcc_result_t;

endpackage : tcc_pkg
`default_nettype wire

### hdl/tcc_cursor_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_cursor_core
// Cursor state (saved column, column, row) and the cell computation for one
// item. State moves on step; the result is combinational from item and state.
// ----------------------------------------------------------------------------
module tcc_cursor_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire tcc_pkg::tcc_item_t   item,
  input  wire logic [15:0]          attribute,
  output tcc_pkg::tcc_result_t      result
);
  import tcc_pkg::*;

  logic [COL_W-1:0] saved_column, saved_column_next;
  logic [COL_W-1:0] current_column, current_column_next;
  logic [ROW_W-1:0] current_row, current_row_next;

  logic [ROW_W-1:0] row_bumped;
  logic [COL_W:0]   tab_pos;

  // Row increment saturating at the last text row
  assign row_bumped = (current_row <= ROW_BUMP_MAX) ? current_row + ROW_W'(1) : current_row;
  // Next tab stop, one bit wider so column 56..63 shows as past the limit
  assign tab_pos    = ({1'b0, current_column} + (COL_W+1)'(8)) & ~(COL_W+1)'(7);

  // Next cursor state and result
  always_comb begin
    saved_column_next   = saved_column;
    current_column_next = current_column;
    current_row_next    = current_row;
    result              = '0;
    if (item.func == FUNC_SET) begin
      saved_column_next   = item.cursor_column;
      current_column_next = item.cursor_column;
      current_row_next    = item.cursor_row;
    end else if (item.char_byte <= CH_LAST_CTRL) begin
      if (item.char_byte == CH_TAB) begin
        if (tab_pos > {1'b0, COL_ADV_MAX}) begin
          current_column_next = '0;
          current_row_next    = row_bumped;
        end else begin
          current_column_next = tab_pos[COL_W-1:0];
        end
      end else if (item.char_byte == CH_LF) begin
        current_column_next = saved_column;
        current_row_next    = row_bumped;
      end
    end else begin
      result.cell_written = 1'b1;
      result.cell_index   = {current_row, current_column} & NT_IDX_MASK;
      result.cell_value   = {{(VAL_W-CHAR_W){1'b0}}, item.char_byte} | attribute | CELL_MARK;
      if (current_column <= COL_ADV_MAX) begin
        current_column_next = current_column + COL_W'(1);
      end
    end
  end

  // Cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      saved_column   <= '0;
      current_column <= '0;
      current_row    <= '0;
    end else if (step) begin
      saved_column   <= saved_column_next;
      current_column <= current_column_next;
      current_row    <= current_row_next;
    end
  end

endmodule : tcc_cursor_core
`default_nettype wire

### hdl/text_console_cursor_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cursor_writer
// Character console cursor engine: set cursor items and character bytes in,
// one nametable cell result out for every item.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake               Contents
// s_axis    in   s_axis_tvalid/tready    one item: set cursor or character
// m_axis    out  m_axis_tvalid/tready    one result item per input item
// cfg       in   cfg_valid/cfg_ready     glyph attribute word
//
// One item per cycle sustained while m_axis_tready stays high; each item passes
// the input register, then the result register; the cursor steps between them.
// Synchronous active-high rst clears cursor, attribute and both valid flags.
// A stalled output holds its result; the input register still takes an
// item while empty, or while the result register is free or being emptied in
// the same cycle. cfg_ready is always high.
// ----------------------------------------------------------------------------
module text_console_cursor_writer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // char_byte[7:0], cursor_column[13:8],
                                          // cursor_row[21:14], zero pad [23:22]
  input  wire logic [0:0]  s_axis_tuser,  // func[0]
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,  // cell_index[13:0], cell_value[29:14],
                                          // zero pad [31:30]
  output      logic [0:0]  m_axis_tuser,  // cell_written[0]
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import tcc_pkg::*;

  logic        in_valid;
  tcc_item_t   in_item;
  logic        out_valid;
  tcc_result_t out_result;
  tcc_result_t core_result;
  logic [15:0] glyph_attribute;
  logic        out_free;
  logic        advance;

  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  // Attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_attribute <= '0;
    end else if (cfg_valid) begin
      glyph_attribute <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.func          <= s_axis_tuser[0];
      in_item.char_byte     <= s_axis_tdata[7:0];
      in_item.cursor_column <= s_axis_tdata[13:8];
      in_item.cursor_row    <= s_axis_tdata[21:14];
    end
  end

  tcc_cursor_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (in_item),
    .attribute (glyph_attribute),
    .result    (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_result.cell_written;
  assign m_axis_tdata  = {2'b00, out_result.cell_value, out_result.cell_index};

endmodule : text_console_cursor_writer
`default_nettype wire
